@@ rtl/core/hsd_pkg.sv @@
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types, constants and the data extraction function for the
// 38/32 Hamming syndrome decoder.
// ----------------------------------------------------------------------------
package hsd_pkg;

    localparam int CW_BITS   = 38;
    localparam int DATA_BITS = 32;
    localparam int CHK_ROWS  = 6;
    localparam int IDX_BITS  = 3;
    localparam int POS_BITS  = 6;

    // check bit positions: 0, 1, 2, 3, 6, 12
    localparam logic [CW_BITS-1:0] PARITY_POS_MASK = 38'h0000_0104F;

    typedef logic [CHK_ROWS-1:0][CW_BITS-1:0] matrix_t;

    typedef enum logic [1:0] {
        STATUS_CLEAN     = 2'd0,
        STATUS_CORRECTED = 2'd1,
        STATUS_UNCORR    = 2'd2
    } status_t;

    typedef struct packed {
        logic                valid;
        logic [CW_BITS-1:0]  word;
        logic [CHK_ROWS-1:0] syn;
    } syn_stage_t;

    typedef struct packed {
        logic                valid;
        logic [CW_BITS-1:0]  word;
        logic [CHK_ROWS-1:0] syn;
        logic [CW_BITS-1:0]  match;
    } match_stage_t;

    // data bits in increasing position order, check positions skipped
    function automatic logic [DATA_BITS-1:0] pack_data(input logic [CW_BITS-1:0] w);
        logic [DATA_BITS-1:0] acc;
        int                   slot;
        acc  = '0;
        slot = 0;
        for (int pos = 0; pos < CW_BITS; pos++)
        begin
            if (!PARITY_POS_MASK[pos] && slot < DATA_BITS)
            begin
                acc[slot] = w[pos];
                slot++;
            end
        end
        return acc;
    endfunction

endpackage

@@ rtl/core/hsd_syndrome.sv @@
// ----------------------------------------------------------------------------
// hsd_syndrome
// Stage 1: GF(2) product of the check matrix and the codeword.
// ----------------------------------------------------------------------------
module hsd_syndrome (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [hsd_pkg::CW_BITS-1:0]         codeword,
    input  hsd_pkg::matrix_t                    matrix,
    output hsd_pkg::syn_stage_t                 stage
);

    logic                               valid_reg;
    logic                               valid_next;
    logic [hsd_pkg::CW_BITS-1:0]        word_reg;
    logic [hsd_pkg::CHK_ROWS-1:0]       syn_reg;
    logic [hsd_pkg::CHK_ROWS-1:0]       syn_next;

    always_comb
    begin
        valid_next = in_valid;
        for (int r = 0; r < hsd_pkg::CHK_ROWS; r++)
        begin
            syn_next[r] = ^(codeword & matrix[r]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= codeword;
        syn_reg  <= syn_next;
    end

    assign stage.valid = valid_reg;
    assign stage.word  = word_reg;
    assign stage.syn   = syn_reg;

endmodule

@@ rtl/core/hsd_match.sv @@
// ----------------------------------------------------------------------------
// hsd_match
// Stage 2: compares the syndrome against every matrix column.
// ----------------------------------------------------------------------------
module hsd_match (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hsd_pkg::syn_stage_t                 in_stage,
    input  hsd_pkg::matrix_t                    matrix,
    output hsd_pkg::match_stage_t               stage
);

    logic                               valid_reg;
    logic [hsd_pkg::CW_BITS-1:0]        word_reg;
    logic [hsd_pkg::CHK_ROWS-1:0]       syn_reg;
    logic [hsd_pkg::CW_BITS-1:0]        match_reg;
    logic [hsd_pkg::CW_BITS-1:0]        match_next;
    logic [hsd_pkg::CHK_ROWS-1:0]       column;

    always_comb
    begin
        match_next = '0;
        column     = '0;
        for (int j = 0; j < hsd_pkg::CW_BITS; j++)
        begin
            for (int r = 0; r < hsd_pkg::CHK_ROWS; r++)
            begin
                column[r] = matrix[r][j];
            end
            match_next[j] = (column == in_stage.syn) && (|in_stage.syn);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_stage.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= in_stage.word;
        syn_reg   <= in_stage.syn;
        match_reg <= match_next;
    end

    assign stage.valid = valid_reg;
    assign stage.word  = word_reg;
    assign stage.syn   = syn_reg;
    assign stage.match = match_reg;

endmodule

@@ rtl/core/hsd_correct.sv @@
// ----------------------------------------------------------------------------
// hsd_correct
// Stage 3: picks the lowest matching position, flips it, extracts data.
// ----------------------------------------------------------------------------
module hsd_correct (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hsd_pkg::match_stage_t               in_stage,
    output logic                                done,
    output logic [hsd_pkg::DATA_BITS-1:0]       data_word,
    output logic [1:0]                          decode_status,
    output logic [hsd_pkg::POS_BITS-1:0]        error_position,
    output logic [hsd_pkg::CHK_ROWS-1:0]        syndrome
);

    logic                               done_reg;
    logic [hsd_pkg::DATA_BITS-1:0]      data_reg;
    logic [hsd_pkg::DATA_BITS-1:0]      data_next;
    hsd_pkg::status_t                   status_reg;
    hsd_pkg::status_t                   status_next;
    logic [hsd_pkg::POS_BITS-1:0]       pos_reg;
    logic [hsd_pkg::POS_BITS-1:0]       pos_next;
    logic [hsd_pkg::CHK_ROWS-1:0]       syn_reg;
    logic [hsd_pkg::CW_BITS-1:0]        lowest;

    always_comb
    begin
        // isolate lowest set match bit
        lowest   = in_stage.match & (~in_stage.match + hsd_pkg::CW_BITS'(1));
        pos_next = '0;
        for (int j = 0; j < hsd_pkg::CW_BITS; j++)
        begin
            if (lowest[j])
            begin
                pos_next = pos_next | hsd_pkg::POS_BITS'(j);
            end
        end
        if (in_stage.syn == '0)
        begin
            status_next = hsd_pkg::STATUS_CLEAN;
            data_next   = hsd_pkg::pack_data(in_stage.word);
        end
        else if (|in_stage.match)
        begin
            status_next = hsd_pkg::STATUS_CORRECTED;
            data_next   = hsd_pkg::pack_data(in_stage.word ^ lowest);
        end
        else
        begin
            status_next = hsd_pkg::STATUS_UNCORR;
            data_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_stage.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        syn_reg    <= in_stage.syn;
    end

    assign done           = done_reg;
    assign data_word      = data_reg;
    assign decode_status  = status_reg;
    assign error_position = pos_reg;
    assign syndrome       = syn_reg;

endmodule

@@ rtl/core/hamming_syndrome_decoder_38_32_core.sv @@
// ----------------------------------------------------------------------------
// hamming_syndrome_decoder_38_32_core
// Single-error-correcting decoder, 38-bit codeword to 32 data bits, with a
// writable 6x38 check matrix.
//
//   channel   signals                                   transfer when
//   --------  ----------------------------------------  -------------------
//   input     start, busy, codeword                     start && !busy
//   result    done, data_word, decode_status,           done
//             error_position, syndrome
//   config    cfg_wr_en, cfg_addr, cfg_data             cfg_wr_en
//
// One codeword per cycle; each result is registered through the syndrome XOR
// tree, column compare, and correct and extract stages after its transfer.
// busy is always low. rst_n clears the pipeline valid bits and the matrix.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module hamming_syndrome_decoder_38_32_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [hsd_pkg::CW_BITS-1:0]         codeword,
    output logic                                done,
    output logic [hsd_pkg::DATA_BITS-1:0]       data_word,
    output logic [1:0]                          decode_status,
    output logic [hsd_pkg::POS_BITS-1:0]        error_position,
    output logic [hsd_pkg::CHK_ROWS-1:0]        syndrome,
    input  logic                                cfg_wr_en,
    input  logic [hsd_pkg::IDX_BITS-1:0]        cfg_addr,
    input  logic [hsd_pkg::CW_BITS-1:0]         cfg_data
);

    hsd_pkg::matrix_t           matrix_reg;
    hsd_pkg::matrix_t           matrix_next;
    hsd_pkg::syn_stage_t        syn_stage;
    hsd_pkg::match_stage_t      match_stage;
    logic                       in_transfer;

    assign busy        = 1'b0;
    assign in_transfer = start && !busy;

    always_comb
    begin
        matrix_next = matrix_reg;
        if (cfg_wr_en && (cfg_addr < hsd_pkg::IDX_BITS'(hsd_pkg::CHK_ROWS)))
        begin
            matrix_next[cfg_addr] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg <= '0;
        end
        else
        begin
            matrix_reg <= matrix_next;
        end
    end

    hsd_syndrome u_syndrome (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_transfer),
        .codeword (codeword),
        .matrix   (matrix_reg),
        .stage    (syn_stage)
    );

    hsd_match u_match (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_stage (syn_stage),
        .matrix   (matrix_reg),
        .stage    (match_stage)
    );

    hsd_correct u_correct (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_stage       (match_stage),
        .done           (done),
        .data_word      (data_word),
        .decode_status  (decode_status),
        .error_position (error_position),
        .syndrome       (syndrome)
    );

    // every input transfer is followed by a done result
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        in_transfer |-> ##3 done)
        else $error("result missing three cycles after input transfer");

    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_transfer, 3))
        else $error("result without matching input transfer");

    a_clean : assert property (@(posedge clk) disable iff (!rst_n)
        (done && decode_status == hsd_pkg::STATUS_CLEAN)
            |-> (syndrome == '0 && error_position == '0))
        else $error("clean status with nonzero syndrome or position");

    a_uncorr : assert property (@(posedge clk) disable iff (!rst_n)
        (done && decode_status == hsd_pkg::STATUS_UNCORR)
            |-> (data_word == '0 && error_position == '0 && syndrome != '0))
        else $error("uncorrectable result fields not cleared");

    a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
        (done && decode_status == hsd_pkg::STATUS_CORRECTED)
            |-> (error_position < hsd_pkg::POS_BITS'(hsd_pkg::CW_BITS)
                 && syndrome != '0))
        else $error("corrected position out of range");

endmodule

@@ bench/tb_hamming_syndrome_decoder_38_32_core.sv @@
// ----------------------------------------------------------------------------
// tb_hamming_syndrome_decoder_38_32_core
// Drives codewords through the 38/32 syndrome decoder under several check
// matrices (reset value, a proper SEC matrix, random, all ones, sparse) and
// compares every result field against an internal decode predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hamming_syndrome_decoder_38_32_core;

    import hsd_pkg::*;

    localparam logic [IDX_BITS-1:0] REG_CHECK_ROW_0 = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_SPARE_6     = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_SPARE_7     = 3'd7;
    localparam logic [CW_BITS-1:0]  ALL_ONES        = {CW_BITS{1'b1}};
    localparam int                  CHECK_POS [CHK_ROWS] = '{0, 1, 2, 3, 6, 12};
    localparam int                  WATCHDOG_LIMIT  = 2000;

    typedef enum int {
        STIM_CODED,
        STIM_NOISE
    } stim_mix_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] data;
        status_t              status;
        logic [POS_BITS-1:0]  pos;
        logic [CHK_ROWS-1:0]  syn;
    } decode_result_t;

    class decode_scoreboard;
        matrix_t        rows;
        decode_result_t pending_decodes[$];
        int             errors;

        function new();
            rows   = '0;
            errors = 0;
        endfunction

        function void write_row(logic [IDX_BITS-1:0] idx, logic [CW_BITS-1:0] value);
            if (idx < CHK_ROWS)
                rows[idx] = value;
        endfunction

        function decode_result_t predict_decode(logic [CW_BITS-1:0] cw);
            decode_result_t      res;
            logic [CHK_ROWS-1:0] col;
            logic [CW_BITS-1:0]  fixed;
            logic                found;
            int                  slot;
            res   = '0;
            fixed = cw;
            found = 1'b0;
            for (int r = 0; r < CHK_ROWS; r++)
                res.syn[r] = ^(cw & rows[r]);
            if (res.syn == '0)
                res.status = STATUS_CLEAN;
            else
            begin
                res.status = STATUS_UNCORR;
                for (int p = 0; p < CW_BITS; p++)
                begin
                    for (int r = 0; r < CHK_ROWS; r++)
                        col[r] = rows[r][p];
                    if (!found && col == res.syn)
                    begin
                        found      = 1'b1;
                        res.pos    = POS_BITS'(p);
                        res.status = STATUS_CORRECTED;
                        fixed[p]   = ~fixed[p];
                    end
                end
            end
            if (res.status != STATUS_UNCORR)
            begin
                slot = 0;
                for (int p = 0; p < CW_BITS; p++)
                begin
                    if (!PARITY_POS_MASK[p])
                    begin
                        res.data[slot] = fixed[p];
                        slot++;
                    end
                end
            end
            return res;
        endfunction

        function void note_codeword(logic [CW_BITS-1:0] cw);
            pending_decodes.push_back(predict_decode(cw));
        endfunction

        function void check_result(logic [DATA_BITS-1:0] data, logic [1:0] status,
                                   logic [POS_BITS-1:0] pos, logic [CHK_ROWS-1:0] syn);
            decode_result_t exp;
            if (pending_decodes.size() == 0)
            begin
                $display("%0t: result with no transfer pending: data_word=%h status=%0d",
                         $time, data, status);
                errors++;
                return;
            end
            exp = pending_decodes.pop_front();
            if (data !== exp.data)
            begin
                $display("%0t: data_word expected %h actual %h", $time, exp.data, data);
                errors++;
            end
            if (status !== exp.status)
            begin
                $display("%0t: decode_status expected %0d actual %0d", $time, exp.status, status);
                errors++;
            end
            if (pos !== exp.pos)
            begin
                $display("%0t: error_position expected %0d actual %0d", $time, exp.pos, pos);
                errors++;
            end
            if (syn !== exp.syn)
            begin
                $display("%0t: syndrome expected %h actual %h", $time, exp.syn, syn);
                errors++;
            end
        endfunction

        function int pending();
            return pending_decodes.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [CW_BITS-1:0]   codeword;
    logic                 done;
    logic [DATA_BITS-1:0] data_word;
    logic [1:0]           decode_status;
    logic [POS_BITS-1:0]  error_position;
    logic [CHK_ROWS-1:0]  syndrome;
    logic                 cfg_wr_en;
    logic [IDX_BITS-1:0]  cfg_addr;
    logic [CW_BITS-1:0]   cfg_data;

    decode_scoreboard     sb;
    int                   quiet_cycles = 0;

    hamming_syndrome_decoder_38_32_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .codeword       (codeword),
        .done           (done),
        .data_word      (data_word),
        .decode_status  (decode_status),
        .error_position (error_position),
        .syndrome       (syndrome),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result(data_word, decode_status, error_position, syndrome);
    end

    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || done === 1'b1 || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d decodes outstanding", $time, sb.pending());
            $display("** hamming_syndrome_decoder_38_32_core: FAILED **");
            $finish;
        end
    end

    function automatic logic [CW_BITS-1:0] rand38();
        return {6'($urandom_range(63, 0)), 32'($urandom)};
    endfunction

    // one-hot columns on the check positions, distinct non-power-of-two elsewhere
    function automatic matrix_t sec_matrix();
        matrix_t             m;
        logic [CHK_ROWS-1:0] col;
        int unsigned         nxt;
        int unsigned         chk;
        m   = '0;
        nxt = 3;
        chk = 0;
        for (int p = 0; p < CW_BITS; p++)
        begin
            if (PARITY_POS_MASK[p])
            begin
                col = CHK_ROWS'(1 << chk);
                chk++;
            end
            else
            begin
                while ((nxt & (nxt - 1)) == 0)
                    nxt++;
                col = CHK_ROWS'(nxt);
                nxt++;
            end
            for (int r = 0; r < CHK_ROWS; r++)
                m[r][p] = col[r];
        end
        return m;
    endfunction

    // valid only while the SEC matrix is loaded
    function automatic logic [CW_BITS-1:0] encode_data(logic [DATA_BITS-1:0] d);
        logic [CW_BITS-1:0] cw;
        decode_result_t     res;
        int                 slot;
        cw   = '0;
        slot = 0;
        for (int p = 0; p < CW_BITS; p++)
        begin
            if (!PARITY_POS_MASK[p])
            begin
                cw[p] = d[slot];
                slot++;
            end
        end
        res = sb.predict_decode(cw);
        for (int r = 0; r < CHK_ROWS; r++)
            if (res.syn[r])
                cw[CHECK_POS[r]] = ~cw[CHECK_POS[r]];
        return cw;
    endfunction

    function automatic logic [CW_BITS-1:0] make_codeword(stim_mix_t mix);
        logic [CW_BITS-1:0] cw;
        int unsigned        pick;
        int unsigned        a;
        int unsigned        b;
        if (mix == STIM_NOISE)
            return rand38();
        pick = $urandom_range(99, 0);
        if (pick < 15)
            return rand38();
        cw = encode_data($urandom);
        a  = $urandom_range(CW_BITS - 1, 0);
        if (pick >= 45)
            cw[a] = ~cw[a];
        if (pick >= 85)
        begin
            b     = (a + $urandom_range(CW_BITS - 1, 1)) % CW_BITS;
            cw[b] = ~cw[b];
        end
        return cw;
    endfunction

    task automatic send_codeword(input logic [CW_BITS-1:0] cw);
        @(negedge clk);
        start    <= 1'b1;
        codeword <= cw;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_codeword(cw);
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CW_BITS-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        sb.write_row(idx, value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_matrix(input matrix_t m);
        for (int r = 0; r < CHK_ROWS; r++)
            write_reg(IDX_BITS'(REG_CHECK_ROW_0 + r), m[r]);
    endtask

    task automatic run_random(input int count, input stim_mix_t mix);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_codeword(make_codeword(mix));
                sent++;
            end
            if ($urandom_range(3, 0) != 0)
                idle_sender($urandom_range(6, 1));
        end
    endtask

    matrix_t            rand_m;
    logic [CW_BITS-1:0] col_keep;
    logic [CW_BITS-1:0] base_cw;

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        codeword  = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // matrix after reset: all words clean
        send_codeword('0);
        send_codeword(ALL_ONES);
        send_codeword(38'h2A_AAAA_AAAA);
        run_random(10, STIM_NOISE);
        wait_for_results();

        load_matrix(sec_matrix());
        write_reg(REG_SPARE_6, ALL_ONES);
        write_reg(REG_SPARE_7, 38'h15_5555_5555);
        send_codeword('0);
        send_codeword(ALL_ONES);
        send_codeword(encode_data(32'hFFFF_FFFF));
        send_codeword(encode_data(32'hA5A5_A5A5));
        base_cw = encode_data(32'h1234_5678);
        send_codeword(base_cw ^ (38'd1 << 0));
        send_codeword(base_cw ^ (38'd1 << 37));
        send_codeword(base_cw ^ (38'd1 << 12));
        send_codeword(base_cw ^ (38'd1 << 4));
        send_codeword(base_cw ^ 38'h3);
        send_codeword(base_cw ^ (38'h3 << 36));
        idle_sender(2);
        run_random(90, STIM_CODED);
        wait_for_results();
        run_random(90, STIM_CODED);
        wait_for_results();

        // random matrices: duplicate columns, lowest match wins
        repeat (2)
        begin
            for (int r = 0; r < CHK_ROWS; r++)
                rand_m[r] = rand38();
            load_matrix(rand_m);
            run_random(50, STIM_NOISE);
            wait_for_results();
        end

        // all columns equal: odd weight corrects position 0
        load_matrix({CHK_ROWS{ALL_ONES}});
        send_codeword(38'h1);
        send_codeword(38'h3);
        send_codeword(ALL_ONES);
        run_random(20, STIM_NOISE);
        wait_for_results();

        // many zero columns
        col_keep = rand38();
        for (int r = 0; r < CHK_ROWS; r++)
            rand_m[r] = rand38() & col_keep;
        load_matrix(rand_m);
        run_random(50, STIM_NOISE);
        wait_for_results();

        load_matrix('0);
        run_random(10, STIM_NOISE);
        wait_for_results();

        load_matrix(sec_matrix());
        run_random(40, STIM_CODED);
        wait_for_results();

        if (sb.errors == 0)
            $display("** hamming_syndrome_decoder_38_32_core: PASSED **");
        else
            $display("** hamming_syndrome_decoder_38_32_core: FAILED **");
        $finish;
    end

endmodule
